/* rtl/core/rc6_pkg.sv */
// rc6_pkg: shared constants, datapath command codes and helpers for the rc6 cipher unit
// used by rc6_ctrl, rc6_datapath and rc6_block_cipher_unit; no dependencies
package rc6_pkg;

  localparam int WORD_W          = 32;
  localparam int KEY_WORDS       = 4;
  localparam int ROUND_COUNT_W   = 5;
  localparam int MAX_ROUNDS_DEF  = 20;
  localparam int ACTION_W        = 2;
  localparam int CFG_INDEX_W     = 3;

  localparam logic [WORD_W-1:0] RC6_P = 32'hB7E15163;
  localparam logic [WORD_W-1:0] RC6_Q = 32'h9E3779B9;

  localparam logic [ROUND_COUNT_W-1:0] ROUND_COUNT_RST = 5'd20;

  // action codes (the unused code runs the key schedule too)
  localparam logic [ACTION_W-1:0] ACT_EXPAND  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ENCRYPT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DECRYPT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY0   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY1   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY2   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY3   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROUNDS = 3'd4;

  // datapath operations
  localparam int DP_OP_W = 4;
  localparam logic [DP_OP_W-1:0] DP_NOP      = 4'd0;
  localparam logic [DP_OP_W-1:0] DP_LOAD     = 4'd1;
  localparam logic [DP_OP_W-1:0] DP_CLEAR    = 4'd2;
  localparam logic [DP_OP_W-1:0] DP_ENC_PRE  = 4'd3;
  localparam logic [DP_OP_W-1:0] DP_MUL_ENC  = 4'd4;
  localparam logic [DP_OP_W-1:0] DP_ENC_RND  = 4'd5;
  localparam logic [DP_OP_W-1:0] DP_ENC_POST = 4'd6;
  localparam logic [DP_OP_W-1:0] DP_DEC_PRE  = 4'd7;
  localparam logic [DP_OP_W-1:0] DP_MUL_DEC  = 4'd8;
  localparam logic [DP_OP_W-1:0] DP_DEC_RND  = 4'd9;
  localparam logic [DP_OP_W-1:0] DP_DEC_POST = 4'd10;
  localparam logic [DP_OP_W-1:0] DP_KS_INIT  = 4'd11;
  localparam logic [DP_OP_W-1:0] DP_KS_A     = 4'd12;
  localparam logic [DP_OP_W-1:0] DP_KS_B     = 4'd13;

  typedef struct packed {
    logic [DP_OP_W-1:0] op;
    logic               wr_en;
    logic               ks_first;
    logic [1:0]         mix_idx;
  } rc6_cmd_t;

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                               input logic [4:0] n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} << n;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                               input logic [4:0] n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} >> n;
    return d[WORD_W-1:0];
  endfunction

endpackage

/* rtl/core/rc6_datapath.sv */
// rc6_datapath: block registers, two multipliers, round-key memory and key schedule words
// driven by rc6_cmd_t commands from rc6_ctrl; uses rc6_pkg
module rc6_datapath
  import rc6_pkg::*;
#(
  parameter int MAX_ROUNDS = MAX_ROUNDS_DEF,
  parameter int DEPTH      = 2 * MAX_ROUNDS + 4,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  rc6_cmd_t                       cmd,
  input  logic [AW-1:0]                  rd_addr0,
  input  logic [AW-1:0]                  rd_addr1,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [KEY_WORDS-1:0][WORD_W-1:0] key,
  input  logic [WORD_W-1:0]              in_a,
  input  logic [WORD_W-1:0]              in_b,
  input  logic [WORD_W-1:0]              in_c,
  input  logic [WORD_W-1:0]              in_d,
  output logic [WORD_W-1:0]              out_a,
  output logic [WORD_W-1:0]              out_b,
  output logic [WORD_W-1:0]              out_c,
  output logic [WORD_W-1:0]              out_d
);

  logic [WORD_W-1:0] wa, wb, wc, wd;
  logic [WORD_W-1:0] p0, p1;
  logic [WORD_W-1:0] rd0, rd1;
  logic [WORD_W-1:0] mix_a, mix_b, kconst;
  logic [KEY_WORDS-1:0][WORD_W-1:0] lw;
  logic [WORD_W-1:0] store [DEPTH];

  logic [WORD_W-1:0] tt, u, enc_a, enc_c, dec_a, dec_c;
  logic [WORD_W-1:0] mul_x, mul_y, ks_src, ks_a, ks_ab, ks_b;

  always_comb begin
    tt    = rotl32(p0, 5'd5);
    u     = rotl32(p1, 5'd5);
    enc_a = rotl32(wa ^ tt, u[4:0]) + rd0;
    enc_c = rotl32(wc ^ u, tt[4:0]) + rd1;
    dec_a = rotr32(wd - rd0, u[4:0]) ^ tt;
    dec_c = rotr32(wb - rd1, tt[4:0]) ^ u;
    // encrypt mixes b and d, decrypt mixes a and c (pre-rotation b and d)
    mul_x = (cmd.op == DP_MUL_DEC) ? wa : wb;
    mul_y = (cmd.op == DP_MUL_DEC) ? wc : wd;
    // first pass of the schedule reads the P/Q sequence instead of memory
    ks_src = cmd.ks_first ? kconst : rd0;
    ks_a   = rotl32(ks_src + mix_a + mix_b, 5'd3);
    ks_ab  = mix_a + mix_b;
    ks_b   = rotl32(lw[cmd.mix_idx] + ks_ab, ks_ab[4:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[wr_addr] <= ks_a;
    end
    rd0 <= store[rd_addr0];
    rd1 <= store[rd_addr1];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        wa <= in_a;
        wb <= in_b;
        wc <= in_c;
        wd <= in_d;
      end
      DP_CLEAR: begin
        wa <= '0;
        wb <= '0;
        wc <= '0;
        wd <= '0;
      end
      DP_ENC_PRE: begin
        wb <= wb + rd0;
        wd <= wd + rd1;
      end
      DP_MUL_ENC, DP_MUL_DEC: begin
        p0 <= mul_x * {mul_x[WORD_W-2:0], 1'b1};
        p1 <= mul_y * {mul_y[WORD_W-2:0], 1'b1};
      end
      DP_ENC_RND: begin
        wa <= wb;
        wb <= enc_c;
        wc <= wd;
        wd <= enc_a;
      end
      DP_ENC_POST: begin
        wa <= wa + rd0;
        wc <= wc + rd1;
      end
      DP_DEC_PRE: begin
        wa <= wa - rd0;
        wc <= wc - rd1;
      end
      DP_DEC_RND: begin
        wa <= dec_a;
        wb <= wa;
        wc <= dec_c;
        wd <= wc;
      end
      DP_DEC_POST: begin
        wb <= wb - rd0;
        wd <= wd - rd1;
      end
      DP_KS_INIT: begin
        wa     <= '0;
        wb     <= '0;
        wc     <= '0;
        wd     <= '0;
        mix_a  <= '0;
        mix_b  <= '0;
        kconst <= RC6_P;
        lw     <= key;
      end
      DP_KS_A: begin
        mix_a <= ks_a;
      end
      DP_KS_B: begin
        mix_b           <= ks_b;
        lw[cmd.mix_idx] <= ks_b;
        kconst          <= kconst + RC6_Q;
      end
      default: begin
      end
    endcase
  end

  assign out_a = wa;
  assign out_b = wb;
  assign out_c = wc;
  assign out_d = wd;

endmodule

/* rtl/core/rc6_ctrl.sv */
// rc6_ctrl: sequencer for key expansion, encrypt and decrypt of the rc6 unit
// issues rc6_cmd_t and memory addresses to rc6_datapath; uses rc6_pkg
module rc6_ctrl
  import rc6_pkg::*;
#(
  parameter int MAX_ROUNDS = MAX_ROUNDS_DEF,
  parameter int DEPTH      = 2 * MAX_ROUNDS + 4,
  parameter int AW         = $clog2(DEPTH),
  parameter int RW         = $clog2(MAX_ROUNDS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ACTION_W-1:0] action,
  input  logic [RW-1:0]       r_eff,
  output logic                busy,
  output logic                done,
  output logic                status,
  output rc6_cmd_t            cmd,
  output logic [AW-1:0]       rd_addr0,
  output logic [AW-1:0]       rd_addr1,
  output logic [AW-1:0]       wr_addr
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ENC_PRE  = 4'd1;
  localparam logic [3:0] S_ENC_MUL  = 4'd2;
  localparam logic [3:0] S_ENC_RND  = 4'd3;
  localparam logic [3:0] S_ENC_POST = 4'd4;
  localparam logic [3:0] S_DEC_PRE  = 4'd5;
  localparam logic [3:0] S_DEC_MUL  = 4'd6;
  localparam logic [3:0] S_DEC_RND  = 4'd7;
  localparam logic [3:0] S_DEC_POST = 4'd8;
  localparam logic [3:0] S_KS_A     = 4'd9;
  localparam logic [3:0] S_KS_B     = 4'd10;

  logic [3:0]    state, state_next;
  logic [RW-1:0] idx, idx_next;
  logic [AW-1:0] ks_i, ks_i_next;
  logic [1:0]    ks_pass, ks_pass_next;
  logic [1:0]    ks_j, ks_j_next;
  logic          sched_ready, sched_ready_next;
  logic          done_next, status_next;

  logic          accept, is_block;
  logic [AW-1:0] last_addr, idx_even, idx_odd;

  assign accept    = start && !busy;
  assign is_block  = (action == ACT_ENCRYPT) || (action == ACT_DECRYPT);
  // 2r+3: last round key, also the last store index of the schedule
  assign last_addr = AW'({r_eff, 1'b1}) + AW'(2);
  assign idx_even  = AW'({idx, 1'b0});
  assign idx_odd   = AW'({idx, 1'b1});
  assign busy      = (state != S_IDLE);
  assign wr_addr   = ks_i;

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    ks_i_next        = ks_i;
    ks_pass_next     = ks_pass;
    ks_j_next        = ks_j;
    sched_ready_next = sched_ready;
    done_next        = 1'b0;
    status_next      = 1'b0;
    cmd              = '{op: DP_NOP, wr_en: 1'b0, ks_first: 1'b0, mix_idx: ks_j};
    rd_addr0         = '0;
    rd_addr1         = AW'(1);

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_block && !sched_ready) begin
            cmd.op      = DP_CLEAR;
            done_next   = 1'b1;
            status_next = 1'b1;
          end else if (action == ACT_ENCRYPT) begin
            cmd.op     = DP_LOAD;
            state_next = S_ENC_PRE;
          end else if (action == ACT_DECRYPT) begin
            cmd.op     = DP_LOAD;
            rd_addr0   = last_addr - AW'(1);
            rd_addr1   = last_addr;
            state_next = S_DEC_PRE;
          end else begin
            cmd.op       = DP_KS_INIT;
            ks_i_next    = '0;
            ks_pass_next = '0;
            ks_j_next    = '0;
            state_next   = S_KS_A;
          end
        end
      end
      S_ENC_PRE: begin
        cmd.op     = DP_ENC_PRE;
        idx_next   = RW'(1);
        state_next = S_ENC_MUL;
      end
      S_ENC_MUL: begin
        cmd.op     = DP_MUL_ENC;
        rd_addr0   = idx_even;
        rd_addr1   = idx_odd;
        state_next = S_ENC_RND;
      end
      S_ENC_RND: begin
        cmd.op   = DP_ENC_RND;
        rd_addr0 = last_addr - AW'(1);
        rd_addr1 = last_addr;
        if (idx == r_eff) begin
          state_next = S_ENC_POST;
        end else begin
          idx_next   = idx + RW'(1);
          state_next = S_ENC_MUL;
        end
      end
      S_ENC_POST: begin
        cmd.op     = DP_ENC_POST;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_DEC_PRE: begin
        cmd.op     = DP_DEC_PRE;
        idx_next   = r_eff;
        state_next = S_DEC_MUL;
      end
      S_DEC_MUL: begin
        cmd.op     = DP_MUL_DEC;
        rd_addr0   = idx_even;
        rd_addr1   = idx_odd;
        state_next = S_DEC_RND;
      end
      S_DEC_RND: begin
        cmd.op = DP_DEC_RND;
        if (idx == RW'(1)) begin
          state_next = S_DEC_POST;
        end else begin
          idx_next   = idx - RW'(1);
          state_next = S_DEC_MUL;
        end
      end
      S_DEC_POST: begin
        cmd.op     = DP_DEC_POST;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_KS_A: begin
        cmd.op       = DP_KS_A;
        cmd.wr_en    = 1'b1;
        cmd.ks_first = (ks_pass == 2'd0);
        rd_addr0     = ks_i;
        state_next   = S_KS_B;
      end
      S_KS_B: begin
        cmd.op    = DP_KS_B;
        ks_j_next = ks_j + 2'd1;
        if (ks_i == last_addr) begin
          ks_i_next    = '0;
          ks_pass_next = ks_pass + 2'd1;
        end else begin
          ks_i_next = ks_i + AW'(1);
        end
        // prefetch the next store entry for the following step
        rd_addr0 = ks_i_next;
        if (ks_i == last_addr && ks_pass == 2'd2) begin
          sched_ready_next = 1'b1;
          done_next        = 1'b1;
          state_next       = S_IDLE;
        end else begin
          state_next = S_KS_A;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sched_ready <= 1'b0;
      done        <= 1'b0;
      status      <= 1'b0;
      idx         <= '0;
      ks_i        <= '0;
      ks_pass     <= '0;
      ks_j        <= '0;
    end else begin
      state       <= state_next;
      sched_ready <= sched_ready_next;
      done        <= done_next;
      status      <= status_next;
      idx         <= idx_next;
      ks_i        <= ks_i_next;
      ks_pass     <= ks_pass_next;
      ks_j        <= ks_j_next;
    end
  end

  // the result strobe always lands after the sequence has returned to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequence still running");

  a_status_done: assert property (@(posedge clk) disable iff (rst) status |-> done)
    else $error("error status without result strobe");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ENC_MUL || state == S_DEC_MUL) |-> (idx >= RW'(1) && idx <= r_eff))
    else $error("round index out of range");

  a_ks_addr: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (wr_addr <= last_addr))
    else $error("key schedule write beyond active store");

  a_block_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_ENC_PRE || state == S_DEC_PRE) |-> sched_ready)
    else $error("block transform started without a key schedule");

endmodule

/* rtl/core/rc6_block_cipher_unit.sv */
// rc6_block_cipher_unit: top level of the rc6 cipher, holds the configuration registers
// and joins rc6_ctrl with rc6_datapath; uses rc6_pkg
//
// usage:
//   configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is always high.
//   index 0..3 set the key words, index 4 the round count r (clamped to 1..MAX_ROUNDS).
//   commands: a transaction is taken when start is high and busy is low, with action
//   and the four block words sampled at that edge.
//   results: done is high for exactly one cycle with out_word_a..d and status valid;
//   the receiver must take it then, there is no back-pressure.
//   sequence from accept to the done strobe:
//     encrypt/decrypt: each round is a multiplier stage, then rotate/add with round
//     keys from the two-port key memory
//     expand: 3*(2r+4) schedule steps, each an S_KS_A state that writes the round-key
//     memory, then an S_KS_B state that updates the key words
//     block command before any expand: strobe in the cycle after accept, status high
//   a new command may be accepted in the same cycle that done is shown.
//   reset: key words clear, round count returns to 20, the key schedule is marked
//   not expanded; round-key memory contents are not cleared.
module rc6_block_cipher_unit
  import rc6_pkg::*;
#(
  parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [ACTION_W-1:0]    action,
  input  logic [WORD_W-1:0]      block_word_a,
  input  logic [WORD_W-1:0]      block_word_b,
  input  logic [WORD_W-1:0]      block_word_c,
  input  logic [WORD_W-1:0]      block_word_d,
  output logic                   done,
  output logic [WORD_W-1:0]      out_word_a,
  output logic [WORD_W-1:0]      out_word_b,
  output logic [WORD_W-1:0]      out_word_c,
  output logic [WORD_W-1:0]      out_word_d,
  output logic                   status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  localparam int DEPTH = 2 * MAX_ROUNDS + 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROUNDS + 1);

  logic [KEY_WORDS-1:0][WORD_W-1:0] key;
  logic [ROUND_COUNT_W-1:0]         round_count;
  logic [5:0]                       rc_ext;
  logic [RW-1:0]                    r_eff;
  rc6_cmd_t                         cmd;
  logic [AW-1:0]                    rd_addr0, rd_addr1, wr_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key         <= '0;
      round_count <= ROUND_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: begin
          key[cfg_index[1:0]] <= cfg_data;
        end
        CFG_ROUNDS: begin
          round_count <= cfg_data[ROUND_COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // clamp the round count to 1..MAX_ROUNDS
  always_comb begin
    rc_ext = {1'b0, round_count};
    if (rc_ext == 6'd0) begin
      r_eff = RW'(1);
    end else if (rc_ext > 6'(MAX_ROUNDS)) begin
      r_eff = RW'(MAX_ROUNDS);
    end else begin
      r_eff = RW'(rc_ext);
    end
  end

  rc6_ctrl #(
    .MAX_ROUNDS(MAX_ROUNDS),
    .DEPTH     (DEPTH),
    .AW        (AW),
    .RW        (RW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .action  (action),
    .r_eff   (r_eff),
    .busy    (busy),
    .done    (done),
    .status  (status),
    .cmd     (cmd),
    .rd_addr0(rd_addr0),
    .rd_addr1(rd_addr1),
    .wr_addr (wr_addr)
  );

  rc6_datapath #(
    .MAX_ROUNDS(MAX_ROUNDS),
    .DEPTH     (DEPTH),
    .AW        (AW)
  ) u_datapath (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr0(rd_addr0),
    .rd_addr1(rd_addr1),
    .wr_addr (wr_addr),
    .key     (key),
    .in_a    (block_word_a),
    .in_b    (block_word_b),
    .in_c    (block_word_c),
    .in_d    (block_word_d),
    .out_a   (out_word_a),
    .out_b   (out_word_b),
    .out_c   (out_word_c),
    .out_d   (out_word_d)
  );

endmodule
